// ----- rtl/tlpw_pkg.sv -----
// Shared types and constants for the two-level page walk memory unit.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package tlpw_pkg;
	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);

	localparam logic [31:0] PRESENT_BIT  = 32'h1;
	localparam logic [31:0] ACCESSED_BIT = 32'h20;
	localparam logic [31:0] DIRTY_BIT    = 32'h40;
	localparam logic [31:0] OFFSET_MASK  = 32'hfff;
	localparam logic [12:0] PAGE_BYTES   = 13'h1000;

	// config register indexes
	localparam logic CFG_PAGE_DIR_BASE = 1'b0;
	localparam logic CFG_PAGING_ENABLE = 1'b1;

	localparam logic [1:0] FLT_OK    = 2'd0;
	localparam logic [1:0] FLT_DIR   = 2'd1;
	localparam logic [1:0] FLT_TBL   = 2'd2;
	localparam logic [1:0] FLT_RANGE = 2'd3;

	// datapath operation codes
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;  // capture request
	localparam logic [3:0] OP_DE_ADDR = 4'd2;  // form directory entry address
	localparam logic [3:0] OP_TE_ADDR = 4'd3;  // form table entry address
	localparam logic [3:0] OP_RD_WORD = 4'd4;  // read byte of entry
	localparam logic [3:0] OP_WR_WORD = 4'd5;  // write byte of entry
	localparam logic [3:0] OP_SET_PA  = 4'd6;  // phys address from table entry
	localparam logic [3:0] OP_DATA    = 4'd7;  // one data byte access
	localparam logic [3:0] OP_CHECK   = 4'd8;  // range check of data halves
	localparam logic [3:0] OP_NEXT    = 4'd9;  // switch to high half

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] idx;    // byte index in word
		logic       dirty;  // set dirty bit on write-back
	} dp_cmd_t;

	typedef struct packed {
		logic       ent_fits;   // current entry address in range
		logic       ent_pres;   // loaded entry present
		logic       data_fits;  // all data bytes in range
		logic       is_wr;
		logic       virt;
		logic       split;
		logic       half;       // 0 low, 1 high
		logic [2:0] len;        // byte count of current half
	} dp_sts_t;
endpackage

// ----- rtl/tlpw_datapath.sv -----
// Datapath: request registers, entry word, address formation and byte memory.
// Depends on tlpw_pkg.
`timescale 1ns / 1ps
module tlpw_datapath (
	input  logic                clk,
	input  logic [31:0]         page_dir_base,
	input  logic                paging_enable,
	input  logic [1:0]          req_type,
	input  logic [31:0]         address,
	input  logic [31:0]         write_data,
	input  logic [2:0]          access_bytes,
	input  tlpw_pkg::dp_cmd_t   cmd,
	output tlpw_pkg::dp_sts_t   sts,
	output logic [31:0]         rdata
);
	logic [7:0]  mem [tlpw_pkg::MEM_BYTES];
	logic [31:0] va_q, wd_q, ent_q, ea_q, pa0_q, pa1_q, rd_q;
	logic [2:0]  n_q, len0_q;
	logic        wr_q, virt_q, half_q;
	logic [7:0]  rbyte;
	logic [1:0]  ridx_q;
	logic        rpend_q, rdata_q;
	logic [2:0]  n_c, len0_c;
	logic [12:0] offn;
	logic [32:0] ea_end, pa0_end, pa1_end;
	logic [31:0] va1, cur_pa, maddr;
	logic [31:0] ent_new;
	logic [2:0]  len1;

	// clamp length and split point
	always_comb begin
		n_c = access_bytes;
		if (access_bytes == 3'd0) n_c = 3'd1;
		else if (access_bytes > 3'd4) n_c = 3'd4;
		offn = {1'b0, address[11:0]} + {10'd0, n_c};
		len0_c = n_c;
		if (req_type[1] && paging_enable && offn > tlpw_pkg::PAGE_BYTES)
			len0_c = 3'(tlpw_pkg::PAGE_BYTES - {1'b0, address[11:0]});
	end

	assign len1    = n_q - len0_q;
	assign va1     = va_q + {29'd0, len0_q};
	assign ea_end  = {1'b0, ea_q} + 33'd4;
	assign pa0_end = {1'b0, pa0_q} + {30'd0, len0_q};
	assign pa1_end = {1'b0, pa1_q} + {30'd0, len1};
	assign cur_pa  = half_q ? pa1_q : pa0_q;
	assign ent_new = ent_q | tlpw_pkg::ACCESSED_BIT | (cmd.dirty ? tlpw_pkg::DIRTY_BIT : 32'd0);

	// memory address for the command
	always_comb begin
		maddr = ea_q + {30'd0, cmd.idx};
		if (cmd.op == tlpw_pkg::OP_DATA) maddr = cur_pa + {30'd0, cmd.idx};
	end

	// byte memory, one port
	always_ff @(posedge clk) begin
		if (cmd.op == tlpw_pkg::OP_WR_WORD)
			mem[maddr[tlpw_pkg::MEM_AW-1:0]] <= ent_new[8*cmd.idx +: 8];
		else if (cmd.op == tlpw_pkg::OP_DATA && wr_q)
			mem[maddr[tlpw_pkg::MEM_AW-1:0]] <=
				wd_q[8*(3'({1'b0, cmd.idx}) + (half_q ? len0_q : 3'd0)) +: 8];
		rbyte <= mem[maddr[tlpw_pkg::MEM_AW-1:0]];
	end

	// registers
	always_ff @(posedge clk) begin
		rpend_q <= (cmd.op == tlpw_pkg::OP_RD_WORD) ||
			(cmd.op == tlpw_pkg::OP_DATA && !wr_q);
		rdata_q <= (cmd.op == tlpw_pkg::OP_DATA);
		if (cmd.op == tlpw_pkg::OP_DATA)
			ridx_q <= 2'(3'({1'b0, cmd.idx}) + (half_q ? len0_q : 3'd0));
		else
			ridx_q <= cmd.idx;
		if (rpend_q) begin
			if (rdata_q) rd_q[8*ridx_q +: 8] <= rbyte;
			else ent_q[8*ridx_q +: 8] <= rbyte;
		end
		case (cmd.op)
			tlpw_pkg::OP_LOAD: begin
				va_q   <= address;
				wd_q   <= write_data;
				n_q    <= n_c;
				len0_q <= len0_c;
				wr_q   <= req_type[0];
				virt_q <= req_type[1] & paging_enable;
				half_q <= 1'b0;
				pa0_q  <= address;
				rd_q   <= '0;
			end
			tlpw_pkg::OP_DE_ADDR: begin
				ea_q <= (page_dir_base & ~tlpw_pkg::OFFSET_MASK) +
					{20'd0, (half_q ? va1[31:22] : va_q[31:22]), 2'b00};
			end
			tlpw_pkg::OP_TE_ADDR: begin
				ea_q <= (ent_q & ~tlpw_pkg::OFFSET_MASK) +
					{20'd0, (half_q ? va1[21:12] : va_q[21:12]), 2'b00};
			end
			tlpw_pkg::OP_SET_PA: begin
				if (half_q) pa1_q <= (ent_q & ~tlpw_pkg::OFFSET_MASK) | {20'd0, va1[11:0]};
				else begin
					pa0_q <= (ent_q & ~tlpw_pkg::OFFSET_MASK) | {20'd0, va_q[11:0]};
					// page-crossing access: walk the high page next
					half_q <= (len1 != 3'd0);
				end
			end
			// data bytes start with the low half
			tlpw_pkg::OP_CHECK: half_q <= 1'b0;
			tlpw_pkg::OP_NEXT: half_q <= 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		sts.ent_fits  = ea_end <= 33'(tlpw_pkg::MEM_BYTES);
		sts.ent_pres  = ent_q[0];
		sts.data_fits = (pa0_end <= 33'(tlpw_pkg::MEM_BYTES)) &&
			(len1 == 3'd0 || pa1_end <= 33'(tlpw_pkg::MEM_BYTES));
		sts.is_wr     = wr_q;
		sts.virt      = virt_q;
		sts.split     = len1 != 3'd0;
		sts.half      = half_q;
		sts.len       = half_q ? len1 : len0_q;
	end
	assign rdata = rd_q;
endmodule

// ----- rtl/tlpw_ctrl.sv -----
// Controller state machine sequencing walk, write-backs and data bytes.
// Depends on tlpw_pkg.
`timescale 1ns / 1ps
module tlpw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        fault_code,
	output logic              rd_clr,
	output tlpw_pkg::dp_cmd_t cmd,
	input  tlpw_pkg::dp_sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_START = 4'd1, S_DE = 4'd2, S_DE_RD = 4'd3,
		S_DE_CHK = 4'd4, S_DE_WB = 4'd5, S_TE = 4'd6, S_TE_RD = 4'd7, S_TE_CHK = 4'd8,
		S_TE_WB = 4'd9, S_PA = 4'd10, S_CHECK = 4'd11, S_DATA = 4'd12, S_DRAIN = 4'd13,
		S_DONE = 4'd14;

	logic [3:0] state_q;
	logic [2:0] cnt_q;
	logic [1:0] flt_q;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_DONE);
	assign fault_code = flt_q;
	assign rd_clr     = flt_q != tlpw_pkg::FLT_OK;

	// command decode
	always_comb begin
		cmd = '{op: tlpw_pkg::OP_NONE, idx: cnt_q[1:0], dirty: 1'b0};
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = tlpw_pkg::OP_LOAD;
			S_DE:     cmd.op = tlpw_pkg::OP_DE_ADDR;
			S_TE:     cmd.op = tlpw_pkg::OP_TE_ADDR;
			S_DE_RD, S_TE_RD: if (!cnt_q[2]) cmd.op = tlpw_pkg::OP_RD_WORD;
			S_DE_WB:  if (!cnt_q[2]) cmd.op = tlpw_pkg::OP_WR_WORD;
			S_TE_WB:  begin
				if (!cnt_q[2]) cmd.op = tlpw_pkg::OP_WR_WORD;
				cmd.dirty = sts.is_wr;
			end
			S_PA:     cmd.op = tlpw_pkg::OP_SET_PA;
			S_CHECK:  cmd.op = tlpw_pkg::OP_CHECK;
			S_DATA: begin
				if (cnt_q < sts.len) cmd.op = tlpw_pkg::OP_DATA;
				else if (sts.split && !sts.half) cmd.op = tlpw_pkg::OP_NEXT;
			end
			default: ;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			flt_q   <= tlpw_pkg::FLT_OK;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_START;
					flt_q   <= tlpw_pkg::FLT_OK;
				end
				S_START: state_q <= sts.virt ? S_DE : S_CHECK;
				S_DE: begin
					state_q <= S_DE_RD;
					cnt_q   <= '0;
				end
				S_DE_RD: begin
					if (!sts.ent_fits) begin
						flt_q <= tlpw_pkg::FLT_RANGE;
						state_q <= S_DONE;
					end else if (cnt_q == 3'd5) state_q <= S_DE_CHK;
					cnt_q <= cnt_q + 3'd1;
				end
				S_DE_CHK: begin
					cnt_q <= '0;
					if (!sts.ent_pres) begin
						flt_q <= tlpw_pkg::FLT_DIR;
						state_q <= S_DONE;
					end else state_q <= S_DE_WB;
				end
				S_DE_WB: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) state_q <= S_TE;
				end
				S_TE: begin
					state_q <= S_TE_RD;
					cnt_q   <= '0;
				end
				S_TE_RD: begin
					if (!sts.ent_fits) begin
						flt_q <= tlpw_pkg::FLT_RANGE;
						state_q <= S_DONE;
					end else if (cnt_q == 3'd5) state_q <= S_TE_CHK;
					cnt_q <= cnt_q + 3'd1;
				end
				S_TE_CHK: begin
					cnt_q <= '0;
					if (!sts.ent_pres) begin
						flt_q <= tlpw_pkg::FLT_TBL;
						state_q <= S_DONE;
					end else state_q <= S_TE_WB;
				end
				S_TE_WB: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) state_q <= S_PA;
				end
				S_PA: begin
					// low half of split: take pa0, then walk the high page
					if (sts.split && !sts.half) state_q <= S_DE;
					else state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q <= '0;
					if (!sts.data_fits) begin
						flt_q <= tlpw_pkg::FLT_RANGE;
						state_q <= S_DONE;
					end else state_q <= S_DATA;
				end
				S_DATA: begin
					if (cnt_q >= sts.len) begin
						cnt_q <= '0;
						// low half done: go on with the high half bytes
						if (sts.split && !sts.half) state_q <= S_DATA;
						else state_q <= S_DRAIN;
					end else cnt_q <= cnt_q + 3'd1;
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready and valid together");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flt_q)) else $error("result dropped");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_START) else $error("accept lost");
`endif
endmodule

// ----- rtl/two_level_page_walk_memory_unit.sv -----
// Top level of the two-level page walk memory unit.
// Depends on tlpw_pkg, tlpw_ctrl and tlpw_datapath.
// Channels: request (valid/ready) with req_type, address, write_data,
// access_bytes; response (valid/ready) with read_data and fault_code;
// config write (cfg_valid/cfg_ready, cfg_index, cfg_data).
// One request at a time. All accesses share one byte-wide memory port:
// each entry read takes 4 byte reads and then drains the read pipeline,
// each write-back 4 byte writes, each data byte one memory access.
// A virtual access walks the directory and table entries first, and a
// page-crossing one walks both pages; faults go straight to the response.
// The response beat and a return to idle come before the next request.
// The result is held in an output register until taken;
// while the receiver stalls no new request is accepted.
// Reset clears the config registers (page_dir_base 0, paging off) and the
// controller; memory contents are undefined until written, no clear pass.
// Config writes are taken at any time and must be issued while idle.
`timescale 1ns / 1ps
module two_level_page_walk_memory_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	input  logic [2:0]  access_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [1:0]  fault_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] pdb_q;
	logic        pe_q;
	logic        rd_clr;
	logic [31:0] rdata;
	tlpw_pkg::dp_cmd_t cmd;
	tlpw_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdb_q <= '0;
			pe_q  <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == tlpw_pkg::CFG_PAGE_DIR_BASE) pdb_q <= cfg_data;
			else if (cfg_index == tlpw_pkg::CFG_PAGING_ENABLE) pe_q <= cfg_data[0];
		end
	end

	tlpw_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.fault_code, .rd_clr, .cmd, .sts
	);

	tlpw_datapath u_dp (
		.clk, .page_dir_base(pdb_q), .paging_enable(pe_q), .req_type, .address,
		.write_data, .access_bytes, .cmd, .sts, .rdata
	);

	assign read_data = (rd_clr || sts.is_wr) ? 32'd0 : rdata;
endmodule
